// ===== hdl/cce_pkg.sv =====
package cce_pkg;

   localparam int CRC_OUT_W = 64;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POLYNOMIAL     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_VALUE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FINAL_XOR      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REFLECT_INPUT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_REFLECT_OUTPUT = 3'd5;

   localparam logic [1:0] WIDTH_16 = 2'd0;
   localparam logic [1:0] WIDTH_32 = 2'd1;
   localparam logic [1:0] WIDTH_64 = 2'd2;

   localparam logic [CSR_DATA_W-1:0] POLY_RESET  = 64'h0000_0000_04C1_1DB7;
   localparam logic [CSR_DATA_W-1:0] INIT_RESET  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [CSR_DATA_W-1:0] FINAL_RESET = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [1:0] width_mode;
      logic       reflect_input;
      logic       reflect_output;
      logic       byte_present;
   } cce_ctrl_type;

endpackage

// ===== hdl/cce_if.sv =====
interface cce_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       last_item;

   modport source (output valid, output data_byte, output byte_present, output last_item,
                   input ready);
   modport sink (input valid, input data_byte, input byte_present, input last_item,
                 output ready);
endinterface

interface cce_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] crc_value;

   modport source (output valid, output crc_value, input ready);
   modport sink (input valid, input crc_value, output ready);
endinterface

// ===== hdl/cce_byte_step.sv =====
module cce_byte_step
   import cce_pkg::*;
#(
   parameter int MAX_CRC_WIDTH = 64
) (
   input  cce_ctrl_type             ctrl,
   input  logic [7:0]               data_byte,
   input  logic [MAX_CRC_WIDTH-1:0] polynomial,
   input  logic [MAX_CRC_WIDTH-1:0] final_xor,
   input  logic [MAX_CRC_WIDTH-1:0] remainder,
   output logic [MAX_CRC_WIDTH-1:0] remainder_next,
   output logic [MAX_CRC_WIDTH-1:0] crc
);

   localparam int SHW = $clog2(MAX_CRC_WIDTH);
   localparam int W16 = (MAX_CRC_WIDTH < 16) ? MAX_CRC_WIDTH : 16;
   localparam int W32 = (MAX_CRC_WIDTH < 32) ? MAX_CRC_WIDTH : 32;

   logic [SHW-1:0]           shift;
   logic [MAX_CRC_WIDTH-1:0] mask;
   logic [MAX_CRC_WIDTH-1:0] poly_al;
   logic [MAX_CRC_WIDTH-1:0] rem_al;
   logic [MAX_CRC_WIDTH-1:0] rem_rev;
   logic [MAX_CRC_WIDTH-1:0] rem_out;
   logic [7:0]               byte_in;

   // Remainder is worked left-aligned so the top bit is always the MSB.
   always_comb begin
      case (ctrl.width_mode)
         WIDTH_16: shift = SHW'(MAX_CRC_WIDTH - W16);
         WIDTH_32: shift = SHW'(MAX_CRC_WIDTH - W32);
         default:  shift = '0;
      endcase
   end

   assign mask    = {MAX_CRC_WIDTH{1'b1}} >> shift;
   assign poly_al = (polynomial & mask) << shift;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_in[i] = ctrl.reflect_input ? data_byte[7-i] : data_byte[i];
      end
   end

   always_comb begin
      rem_al = (remainder & mask) << shift;
      if (ctrl.byte_present) begin
         rem_al[MAX_CRC_WIDTH-1 -: 8] = rem_al[MAX_CRC_WIDTH-1 -: 8] ^ byte_in;
         for (int k = 0; k < 8; k++) begin
            rem_al = rem_al[MAX_CRC_WIDTH-1] ? ((rem_al << 1) ^ poly_al) : (rem_al << 1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
         rem_rev[i] = rem_al[MAX_CRC_WIDTH-1-i];
      end
   end

   assign rem_out        = rem_al >> shift;
   assign remainder_next = rem_out;
   assign crc            = (ctrl.reflect_output ? rem_rev : rem_out) ^ (final_xor & mask);

endmodule

// ===== hdl/configurable_crc_engine_unit.sv =====
// Configurable CRC engine, one message byte per beat, 16/32/64-bit MSB-first CRC.
// req_chan: data_byte, byte_present (0 = empty beat), last_item (ends message).
// rsp_chan: crc_value, one beat per message, zero-extended from the CRC width.
// csr_*: write-only registers (width_mode, polynomial, initial_value, final_xor,
//   reflect_input, reflect_output) at indexes 0..5; write only while idle.
// A last beat passes from the input stage into the result register, which drives rsp_chan.
// Throughput: one beat per cycle, but a last beat waits for a free result register;
//   the whole byte update (eight shift/XOR steps) is one combinational pass
//   between the input stage and the remainder/result registers.
// A new beat is taken while a finished CRC waits in the result register; only a
//   last beat waits for that register to be free, so a stalled receiver holds
//   the pipeline once a second CRC is ready.
// Reset (synchronous, active high) loads the register defaults (CRC-32), clears
//   both stages and makes the next beat start a new message.
module configurable_crc_engine_unit
   import cce_pkg::*;
#(
   parameter int MAX_CRC_WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   cce_req_if.sink                req_chan,
   cce_rsp_if.source              rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [1:0]               width_mode_ff, width_mode_in;
   logic [MAX_CRC_WIDTH-1:0] polynomial_ff, polynomial_in;
   logic [MAX_CRC_WIDTH-1:0] initial_ff, initial_in;
   logic [MAX_CRC_WIDTH-1:0] final_xor_ff, final_xor_in;
   logic                     refl_in_ff, refl_in_in;
   logic                     refl_out_ff, refl_out_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic [7:0]               s1_byte_ff, s1_byte_in;
   logic                     s1_present_ff, s1_present_in;
   logic                     s1_last_ff, s1_last_in;

   logic [MAX_CRC_WIDTH-1:0] remainder_ff, remainder_in;
   logic                     msg_start_ff, msg_start_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CRC_OUT_W-1:0]     crc_ff, crc_in;

   logic                     out_free;
   logic                     s1_advance;
   cce_ctrl_type             step_ctrl;
   logic [MAX_CRC_WIDTH-1:0] step_rem;
   logic [MAX_CRC_WIDTH-1:0] step_rem_next;
   logic [MAX_CRC_WIDTH-1:0] step_crc;

   // Register file
   always_comb begin
      width_mode_in = width_mode_ff;
      polynomial_in = polynomial_ff;
      initial_in    = initial_ff;
      final_xor_in  = final_xor_ff;
      refl_in_in    = refl_in_ff;
      refl_out_in   = refl_out_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_WIDTH_MODE:     width_mode_in = csr_wdata[1:0];
            REG_POLYNOMIAL:     polynomial_in = csr_wdata[MAX_CRC_WIDTH-1:0];
            REG_INITIAL_VALUE:  initial_in    = csr_wdata[MAX_CRC_WIDTH-1:0];
            REG_FINAL_XOR:      final_xor_in  = csr_wdata[MAX_CRC_WIDTH-1:0];
            REG_REFLECT_INPUT:  refl_in_in    = csr_wdata[0];
            REG_REFLECT_OUTPUT: refl_out_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_byte_in    = s1_byte_ff;
      s1_present_in = s1_present_ff;
      s1_last_in    = s1_last_ff;
      if (req_chan.ready) begin
         s1_valid_in   = req_chan.valid;
         s1_byte_in    = req_chan.data_byte;
         s1_present_in = req_chan.byte_present;
         s1_last_in    = req_chan.last_item;
      end
   end

   // Byte update
   assign step_ctrl = '{width_mode:     width_mode_ff,
                        reflect_input:  refl_in_ff,
                        reflect_output: refl_out_ff,
                        byte_present:   s1_present_ff};
   assign step_rem  = msg_start_ff ? initial_ff : remainder_ff;

   cce_byte_step #(
      .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
   ) u_step (
      .ctrl           (step_ctrl),
      .data_byte      (s1_byte_ff),
      .polynomial     (polynomial_ff),
      .final_xor      (final_xor_ff),
      .remainder      (step_rem),
      .remainder_next (step_rem_next),
      .crc            (step_crc)
   );

   always_comb begin
      remainder_in = remainder_ff;
      msg_start_in = msg_start_ff;
      rsp_valid_in = rsp_valid_ff;
      crc_in       = crc_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance) begin
         remainder_in = step_rem_next;
         msg_start_in = s1_last_ff;
         if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            crc_in       = CRC_OUT_W'(step_crc);
         end
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.crc_value = crc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_mode_ff <= WIDTH_32;
         polynomial_ff <= POLY_RESET[MAX_CRC_WIDTH-1:0];
         initial_ff    <= INIT_RESET[MAX_CRC_WIDTH-1:0];
         final_xor_ff  <= FINAL_RESET[MAX_CRC_WIDTH-1:0];
         refl_in_ff    <= 1'b1;
         refl_out_ff   <= 1'b1;
         s1_valid_ff   <= 1'b0;
         remainder_ff  <= '0;
         msg_start_ff  <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_mode_ff <= width_mode_in;
         polynomial_ff <= polynomial_in;
         initial_ff    <= initial_in;
         final_xor_ff  <= final_xor_in;
         refl_in_ff    <= refl_in_in;
         refl_out_ff   <= refl_out_in;
         s1_valid_ff   <= s1_valid_in;
         remainder_ff  <= remainder_in;
         msg_start_ff  <= msg_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_present_ff <= s1_present_in;
      s1_last_ff    <= s1_last_in;
      crc_ff        <= crc_in;
   end

   // A last beat never overwrites a CRC the receiver has not taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_chan.ready |=> s1_valid_ff)
      else $error("last beat left stage while result stalled");

   // A new result appears only from a last beat leaving the input stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(s1_advance && s1_last_ff))
      else $error("result raised without a last beat");

   // A message restarts only after a last beat.
   a_msg_restart: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(msg_start_ff) |-> $past(s1_advance && s1_last_ff))
      else $error("message start set without a last beat");

   // Input stage is busy only when it holds a beat.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("input stalled while stage empty");

endmodule
